>>> rtl/lphs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_pkg
// Shared types, constants and helpers of the linear-probe hash set insert unit.
// ----------------------------------------------------------------------------
package lphs_pkg;

   localparam int SLOT_COUNT  = 1024;
   localparam int SLOT_BITS   = $clog2(SLOT_COUNT);
   localparam int CAP_BITS    = SLOT_BITS + 1;
   localparam int CFG_BITS    = 11;
   localparam int KEY_BITS    = 64;
   localparam int KEY_IN_BITS = 64;
   localparam int HASH_BITS   = 64;
   localparam int DIGIT_BITS  = 4;
   localparam int DIV_STEPS   = HASH_BITS / DIGIT_BITS;
   localparam int STEP_BITS   = $clog2(DIV_STEPS);
   localparam int ADDR_BITS   = 3;
   localparam int DATA_BITS   = 32;

   localparam logic [ADDR_BITS-1:0] REG_CAPACITY = ADDR_BITS'(0);
   localparam logic [CFG_BITS-1:0]  CAP_RESET    = CFG_BITS'(1024);

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_PRESENT  = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_CLEAR,
      B_IDLE,
      B_READ,
      B_CHECK
   } back_state_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]  key;
      logic [SLOT_BITS-1:0] home;
   } probe_req_type;

   typedef struct packed {
      status_type           status;
      logic [SLOT_BITS-1:0] slot;
      logic [CAP_BITS-1:0]  occupancy;
   } result_type;

   function automatic logic [CAP_BITS-1:0] eff_cap(input logic [CFG_BITS-1:0] c);
      logic [CAP_BITS-1:0] r;
      if (c == '0) begin
         r = CAP_BITS'(1);
      end else if (c > CFG_BITS'(SLOT_COUNT)) begin
         r = CAP_BITS'(SLOT_COUNT);
      end else begin
         r = CAP_BITS'(c);
      end
      return r;
   endfunction

endpackage

>>> rtl/lphs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_front
// Accepts a beat and reduces its hash modulo the capacity, four bits a cycle.
// ----------------------------------------------------------------------------
module lphs_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [lphs_pkg::KEY_IN_BITS-1:0]    req_key,
   input  logic [lphs_pkg::HASH_BITS-1:0]      req_hash_value,
   input  logic [lphs_pkg::CAP_BITS-1:0]       cap,
   input  logic                                clearing,
   input  logic                                q_full,
   output logic                                q_push,
   output lphs_pkg::probe_req_type             q_data
);

   lphs_pkg::front_state_type             state_ff, state_in;
   logic [lphs_pkg::KEY_BITS-1:0]         key_ff, key_in;
   logic [lphs_pkg::HASH_BITS-1:0]        hash_ff, hash_in;
   logic [lphs_pkg::CAP_BITS-1:0]         rem_ff, rem_in;
   logic [lphs_pkg::STEP_BITS-1:0]        cnt_ff, cnt_in;
   logic                                  accept;

   assign full   = (state_ff != lphs_pkg::F_IDLE) || clearing;
   assign accept = push && !full;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lphs_pkg::F_IDLE: begin
            if (accept) state_in = lphs_pkg::F_DIV;
         end
         lphs_pkg::F_DIV: begin
            if (cnt_ff == lphs_pkg::STEP_BITS'(lphs_pkg::DIV_STEPS - 1)) begin
               state_in = lphs_pkg::F_PUSH;
            end
         end
         lphs_pkg::F_PUSH: begin
            if (!q_full) state_in = lphs_pkg::F_IDLE;
         end
         default: state_in = lphs_pkg::F_IDLE;
      endcase
   end

   always_comb begin
      logic [lphs_pkg::CAP_BITS:0]    t;
      logic [lphs_pkg::CAP_BITS-1:0]  r;
      logic [lphs_pkg::HASH_BITS-1:0] h;
      r      = rem_ff;
      h      = hash_ff;
      key_in = key_ff;
      cnt_in = cnt_ff;
      q_push = 1'b0;
      for (int i = 0; i < lphs_pkg::DIGIT_BITS; i++) begin
         t = {r, h[lphs_pkg::HASH_BITS-1]};
         if (t >= {1'b0, cap}) t = t - {1'b0, cap};
         r = t[lphs_pkg::CAP_BITS-1:0];
         h = {h[lphs_pkg::HASH_BITS-2:0], 1'b0};
      end
      rem_in  = rem_ff;
      hash_in = hash_ff;
      case (state_ff)
         lphs_pkg::F_IDLE: begin
            if (accept) begin
               key_in  = req_key[lphs_pkg::KEY_BITS-1:0];
               hash_in = req_hash_value;
               rem_in  = '0;
               cnt_in  = '0;
            end
         end
         lphs_pkg::F_DIV: begin
            rem_in  = r;
            hash_in = h;
            cnt_in  = cnt_ff + lphs_pkg::STEP_BITS'(1);
         end
         lphs_pkg::F_PUSH: begin
            q_push = !q_full;
         end
         default: ;
      endcase
   end

   assign q_data.key  = key_ff;
   assign q_data.home = rem_ff[lphs_pkg::SLOT_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lphs_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      key_ff  <= key_in;
      hash_ff <= hash_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

endmodule

>>> rtl/lphs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_queue
// Two-entry queue between the front and the probe engine.
// ----------------------------------------------------------------------------
module lphs_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  lphs_pkg::probe_req_type wr_data,
   output logic                    q_full,
   input  logic                    rd_en,
   output logic                    q_empty,
   output lphs_pkg::probe_req_type rd_data
);

   lphs_pkg::probe_req_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_wr, do_rd;

   assign q_full  = (cnt_ff == 2'd2);
   assign q_empty = (cnt_ff == 2'd0);
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_wr;
      rd_ptr_in = rd_ptr_ff ^ do_rd;
      cnt_in    = cnt_ff + 2'(do_wr) - 2'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_wr) entry_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

>>> rtl/lphs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_back
// Probe engine: walks the slot memory from the home slot and holds the result.
// ----------------------------------------------------------------------------
module lphs_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [lphs_pkg::CAP_BITS-1:0]   cap,
   input  logic                            q_empty,
   input  lphs_pkg::probe_req_type         q_head,
   output logic                            q_pop,
   output logic                            clearing,
   input  logic                            pop,
   output logic                            empty,
   output lphs_pkg::result_type            result
);

   lphs_pkg::back_state_type              state_ff, state_in;
   logic [lphs_pkg::SLOT_BITS-1:0]        pos_ff, pos_in;
   logic [lphs_pkg::CAP_BITS-1:0]         n_ff, n_in;
   logic [lphs_pkg::KEY_BITS-1:0]         key_ff, key_in;
   logic [lphs_pkg::CAP_BITS-1:0]         count_ff, count_in;
   logic [lphs_pkg::SLOT_BITS-1:0]        clr_ff, clr_in;
   logic                                  out_valid_ff, out_valid_in;
   lphs_pkg::result_type                  out_ff, out_in;
   logic [lphs_pkg::KEY_BITS:0]           mem [lphs_pkg::SLOT_COUNT];
   logic [lphs_pkg::KEY_BITS:0]           rd_ff;
   logic                                  hit_empty, hit_equal, wrapped;
   logic [lphs_pkg::CAP_BITS-1:0]         pos_next;

   assign clearing  = (state_ff == lphs_pkg::B_CLEAR);
   assign empty     = !out_valid_ff;
   assign result    = out_ff;
   assign hit_empty = !rd_ff[lphs_pkg::KEY_BITS];
   assign hit_equal = rd_ff[lphs_pkg::KEY_BITS-1:0] == key_ff;
   assign wrapped   = (n_ff + lphs_pkg::CAP_BITS'(1)) == cap;
   assign pos_next  = lphs_pkg::CAP_BITS'(pos_ff) + lphs_pkg::CAP_BITS'(1);
   assign q_pop     = (state_ff == lphs_pkg::B_IDLE) && !q_empty && !out_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lphs_pkg::B_CLEAR: begin
            if (clr_ff == lphs_pkg::SLOT_BITS'(lphs_pkg::SLOT_COUNT - 1)) begin
               state_in = lphs_pkg::B_IDLE;
            end
         end
         lphs_pkg::B_IDLE: begin
            if (q_pop) state_in = lphs_pkg::B_READ;
         end
         lphs_pkg::B_READ: state_in = lphs_pkg::B_CHECK;
         lphs_pkg::B_CHECK: begin
            if (hit_empty || hit_equal || wrapped) begin
               state_in = lphs_pkg::B_IDLE;
            end else begin
               state_in = lphs_pkg::B_READ;
            end
         end
         default: state_in = lphs_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      pos_in       = pos_ff;
      n_in         = n_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      clr_in       = clr_ff + lphs_pkg::SLOT_BITS'(1);
      out_valid_in = out_valid_ff && !pop;
      out_in       = out_ff;
      case (state_ff)
         lphs_pkg::B_IDLE: begin
            if (q_pop) begin
               key_in = q_head.key;
               pos_in = q_head.home;
               n_in   = '0;
            end
         end
         lphs_pkg::B_CHECK: begin
            if (hit_empty) begin
               count_in         = count_ff + lphs_pkg::CAP_BITS'(1);
               out_valid_in     = 1'b1;
               out_in.status    = lphs_pkg::ST_INSERTED;
               out_in.slot      = pos_ff;
               out_in.occupancy = count_ff + lphs_pkg::CAP_BITS'(1);
            end else if (hit_equal) begin
               out_valid_in     = 1'b1;
               out_in.status    = lphs_pkg::ST_PRESENT;
               out_in.slot      = pos_ff;
               out_in.occupancy = count_ff;
            end else if (wrapped) begin
               out_valid_in     = 1'b1;
               out_in.status    = lphs_pkg::ST_FULL;
               out_in.slot      = '0;
               out_in.occupancy = count_ff;
            end else begin
               n_in   = n_ff + lphs_pkg::CAP_BITS'(1);
               pos_in = (pos_next == cap) ? '0 : pos_next[lphs_pkg::SLOT_BITS-1:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lphs_pkg::B_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      pos_ff <= pos_in;
      n_ff   <= n_in;
      key_ff <= key_in;
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == lphs_pkg::B_CLEAR) begin
         mem[clr_ff] <= '0;
      end else if (state_ff == lphs_pkg::B_CHECK && hit_empty) begin
         mem[pos_ff] <= {1'b1, key_ff};
      end
      if (state_ff == lphs_pkg::B_READ) begin
         rd_ff <= mem[pos_ff];
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lphs_pkg::CAP_BITS'(lphs_pkg::SLOT_COUNT))
      else $error("occupancy beyond slot count");
   a_check_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == lphs_pkg::B_CHECK |-> $past(state_ff) == lphs_pkg::B_READ)
      else $error("check without read");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lphs_pkg::B_CHECK && (hit_empty || hit_equal || wrapped))
      |-> !out_valid_ff)
      else $error("result overwritten");
   a_count_on_insert: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lphs_pkg::B_CHECK && hit_empty)
      |=> count_ff == $past(count_ff) + lphs_pkg::CAP_BITS'(1))
      else $error("insert not counted");
`endif

endmodule

>>> rtl/linear_probe_hash_set_insert_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_set_insert_unit
// Insert-only open-addressing hash set with linear probing.
// ----------------------------------------------------------------------------
// Usage: push a beat of key and hash while full is low. The front reduces the
// hash modulo the capacity at four bits a cycle, then hands the home slot to
// the probe engine through a two-entry queue. Each probe of the engine passes
// through a read state on the registered slot memory and a check state. The
// front takes a new beat once it has passed its item on, so it can take a new
// beat while the engine still probes an earlier one. A result sits on the
// rsp_ ports while empty is low and leaves on pop; while it waits the engine
// holds, the queue fills and full rises. After reset the engine clears the
// 1024 slot valid marks, one per cycle, and full stays high while it clears;
// capacity writes are taken. Capacity (register 0) is to be written only
// while the unit is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module linear_probe_hash_set_insert_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic [lphs_pkg::KEY_IN_BITS-1:0]   req_key,
   input  logic [lphs_pkg::HASH_BITS-1:0]     req_hash_value,
   output logic                               empty,
   input  logic                               pop,
   output logic [1:0]                         rsp_status,
   output logic [lphs_pkg::SLOT_BITS-1:0]     rsp_slot,
   output logic [lphs_pkg::CAP_BITS-1:0]      rsp_occupancy,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [lphs_pkg::ADDR_BITS-1:0]     paddr,
   input  logic [lphs_pkg::DATA_BITS-1:0]     pwdata,
   output logic [lphs_pkg::DATA_BITS-1:0]     prdata,
   output logic                               pready
);

   logic [lphs_pkg::CFG_BITS-1:0] cap_ff, cap_in;
   logic [lphs_pkg::CAP_BITS-1:0] cap_eff;
   logic                          clearing;
   logic                          q_push, q_full, q_pop, q_empty;
   lphs_pkg::probe_req_type       q_wdata, q_head;
   lphs_pkg::result_type          result;

   assign pready  = 1'b1;
   assign cap_eff = lphs_pkg::eff_cap(cap_ff);
   assign prdata  = (paddr == lphs_pkg::REG_CAPACITY) ?
                    lphs_pkg::DATA_BITS'(cap_ff) : '0;

   always_comb begin
      cap_in = cap_ff;
      if (psel && penable && pwrite && paddr == lphs_pkg::REG_CAPACITY) begin
         cap_in = pwdata[lphs_pkg::CFG_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= lphs_pkg::CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   lphs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_key        (req_key),
      .req_hash_value (req_hash_value),
      .cap            (cap_eff),
      .clearing       (clearing),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_data         (q_wdata)
   );

   lphs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wdata),
      .q_full  (q_full),
      .rd_en   (q_pop),
      .q_empty (q_empty),
      .rd_data (q_head)
   );

   lphs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cap      (cap_eff),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .clearing (clearing),
      .pop      (pop),
      .empty    (empty),
      .result   (result)
   );

   assign rsp_status    = result.status;
   assign rsp_slot      = result.slot;
   assign rsp_occupancy = result.occupancy;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the linear-probe hash set insert unit.
// Keys and hashes are pushed through the queue-style input while results are
// popped with random stalls. A scoreboard keeps its own copy of the slot table
// and capacity, predicts status, slot and occupancy for every accepted beat,
// and compares each popped beat against the oldest prediction. Capacity is
// reprogrammed between phases, including zero, one, saturating values and the
// full table size.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int DRAIN_CYCLES   = 60;
   localparam logic [lphs_pkg::ADDR_BITS-1:0] SPARE_ADDR = lphs_pkg::ADDR_BITS'(4);

   typedef struct {
      lphs_pkg::status_type           status;
      logic [lphs_pkg::SLOT_BITS-1:0] slot;
      logic [lphs_pkg::CAP_BITS-1:0]  occupancy;
   } insert_result_type;

   class hash_set_scoreboard;
      logic [lphs_pkg::KEY_BITS-1:0] key_table [lphs_pkg::SLOT_COUNT];
      bit                            occupied [lphs_pkg::SLOT_COUNT];
      logic [lphs_pkg::CAP_BITS-1:0] stored;
      logic [lphs_pkg::CFG_BITS-1:0] capacity;
      insert_result_type             pending [$];
      int                            errors;

      function void clear_table();
         foreach (occupied[i]) occupied[i] = 0;
         stored   = '0;
         capacity = lphs_pkg::CAP_RESET;
         errors   = 0;
      endfunction

      function void set_capacity(logic [lphs_pkg::ADDR_BITS-1:0] addr,
                                 logic [lphs_pkg::DATA_BITS-1:0] value);
         if (addr == lphs_pkg::REG_CAPACITY) capacity = value[lphs_pkg::CFG_BITS-1:0];
      endfunction

      function void note_insert(logic [lphs_pkg::KEY_IN_BITS-1:0] key,
                                logic [lphs_pkg::HASH_BITS-1:0] hash);
         int unsigned       cap;
         int unsigned       pos;
         insert_result_type r;
         cap = (capacity == 0) ? 1 :
               (capacity > lphs_pkg::SLOT_COUNT) ? lphs_pkg::SLOT_COUNT : capacity;
         pos = int'(hash % 64'(cap));
         r.status = lphs_pkg::ST_FULL;
         r.slot   = '0;
         for (int n = 0; n < cap; n++) begin
            if (!occupied[pos]) begin
               occupied[pos]  = 1;
               key_table[pos] = key[lphs_pkg::KEY_BITS-1:0];
               stored++;
               r.status = lphs_pkg::ST_INSERTED;
               r.slot   = pos[lphs_pkg::SLOT_BITS-1:0];
               break;
            end
            if (key_table[pos] == key[lphs_pkg::KEY_BITS-1:0]) begin
               r.status = lphs_pkg::ST_PRESENT;
               r.slot   = pos[lphs_pkg::SLOT_BITS-1:0];
               break;
            end
            pos = (pos + 1 >= cap) ? 0 : pos + 1;
         end
         r.occupancy = stored;
         pending.push_back(r);
      endfunction

      function void check_result(logic [1:0] status, logic [lphs_pkg::SLOT_BITS-1:0] slot,
                                 logic [lphs_pkg::CAP_BITS-1:0] occupancy);
         insert_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result beat status=%0d slot=%0d occupancy=%0d",
                     $time, status, slot, occupancy);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, status);
            errors++;
         end
         if (slot !== e.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, e.slot, slot);
            errors++;
         end
         if (occupancy !== e.occupancy) begin
            $display("%0t: occupancy expected %0d actual %0d", $time, e.occupancy, occupancy);
            errors++;
         end
      endfunction
   endclass

   logic                             clock = 0;
   logic                             reset = 1;
   logic                             push = 0;
   logic                             full;
   logic [lphs_pkg::KEY_IN_BITS-1:0] req_key = '0;
   logic [lphs_pkg::HASH_BITS-1:0]   req_hash_value = '0;
   logic                             empty;
   logic                             pop = 0;
   logic [1:0]                       rsp_status;
   logic [lphs_pkg::SLOT_BITS-1:0]   rsp_slot;
   logic [lphs_pkg::CAP_BITS-1:0]    rsp_occupancy;
   logic                             psel = 0;
   logic                             penable = 0;
   logic                             pwrite = 0;
   logic [lphs_pkg::ADDR_BITS-1:0]   paddr = '0;
   logic [lphs_pkg::DATA_BITS-1:0]   pwdata = '0;
   logic [lphs_pkg::DATA_BITS-1:0]   prdata;
   logic                             pready;

   hash_set_scoreboard sb = new();
   bit                 no_gaps = 0;
   int                 idle_cycles = 0;
   logic [63:0]        key_pool [32];

   linear_probe_hash_set_insert_unit dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((push && !full) || (pop && !empty) || (psel && penable && pwrite && pready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (push && !full) sb.note_insert(req_key, req_hash_value);
         if (pop && !empty) sb.check_result(rsp_status, rsp_slot, rsp_occupancy);
         if (psel && penable && pwrite && pready) sb.set_capacity(paddr, pwdata);
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   function automatic int draw_gap();
      return no_gaps ? 0 : $urandom_range(0, 7);
   endfunction

   task automatic send_key(logic [63:0] key, logic [63:0] hash);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         push <= 0;
         repeat (gap) @(posedge clock);
      end
      push           <= 1;
      req_key        <= key;
      req_hash_value <= hash;
      do @(posedge clock); while (full);
   endtask

   task automatic write_capacity(logic [lphs_pkg::ADDR_BITS-1:0] addr,
                                 logic [lphs_pkg::DATA_BITS-1:0] value);
      psel    <= 1;
      penable <= 0;
      pwrite  <= 1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel    <= 0;
      penable <= 0;
      pwrite  <= 0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      push <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // result side: random pop stalls
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            pop <= 0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1;
         do @(posedge clock); while (empty);
      end
   end

   initial begin
      logic [63:0]                    key;
      logic [63:0]                    hash;
      logic [lphs_pkg::DATA_BITS-1:0] caps [10];
      caps = '{32'd0, 32'd1, 32'd2, 32'd5, 32'd33, 32'd1500, 32'd2047, 32'd64,
               32'd200, 32'd1024};
      sb.clear_table();
      foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, collisions, wrap, duplicates
      send_key(64'd0, 64'd0);
      send_key(64'd0, 64'd0);
      send_key('1, 64'd0);
      send_key('1, '1);
      send_key(64'h8000_0000_0000_0001, 64'd1023);
      send_key(64'h1234, 64'd1023);
      send_key(64'h1234, 64'd2047);
      send_key(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
      send_key(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
      wait_idle();
      write_capacity(lphs_pkg::REG_CAPACITY, 32'd1);
      send_key(64'd0, 64'd77);
      send_key(64'd99, '1);
      wait_idle();
      write_capacity(SPARE_ADDR, 32'd3);
      write_capacity(lphs_pkg::REG_CAPACITY, 32'd0);
      send_key(64'd99, 64'd5);
      wait_idle();

      foreach (caps[p]) begin
         write_capacity(lphs_pkg::REG_CAPACITY, caps[p]);
         no_gaps = (p % 3 == 2);
         repeat (70) begin
            key  = ($urandom_range(0, 9) < 6) ? key_pool[$urandom_range(0, 31)]
                                              : {$urandom, $urandom};
            hash = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 4095))
                                               : {$urandom, $urandom};
            send_key(key, hash);
         end
         wait_idle();
      end

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/lphs_pkg.sv
rtl/lphs_front.sv
rtl/lphs_queue.sv
rtl/lphs_back.sv
rtl/linear_probe_hash_set_insert_unit.sv
sim/tb_top.sv
